// ===== rtl/core/tnrx_pkg.sv =====
// Package for the telnet receive command parser.
// Holds the byte codes, result kinds, parse phase type and the result word struct.
// No dependencies.
package tnrx_pkg;

    // Command byte codes
    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_DONT = 8'd254;
    localparam logic [7:0] CODE_DO   = 8'd253;
    localparam logic [7:0] CODE_WONT = 8'd252;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_SE   = 8'd240;

    // Result kinds; negotiation kinds run WILL, WONT, DO, DONT upward from KIND_WILL
    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_WILL   = 3'd1;
    localparam logic [2:0] KIND_SBBYTE = 3'd5;
    localparam logic [2:0] KIND_SBEND  = 3'd6;

    typedef enum logic [2:0] {
        PH_DATA        = 3'd0,
        PH_IAC         = 3'd1,
        PH_VERB_OPT    = 3'd2,
        PH_VERB_ESC    = 3'd3,
        PH_SB_OPT      = 3'd4,
        PH_SB_OPT_ESC  = 3'd5,
        PH_SB_BODY     = 3'd6,
        PH_SB_BODY_ESC = 3'd7
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [7:0] sub_option;
    } result_t;

endpackage

// ===== rtl/core/tnrx_parser.sv =====
// Telnet parse state machine: phase, pending verb and open option.
// One byte per enabled cycle, at most one result word out. Uses tnrx_pkg.
module tnrx_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output tnrx_pkg::result_t res
);
    import tnrx_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] verb_reg, verb_next;
    logic [7:0] opt_reg, opt_next;
    logic       emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DATA;
            verb_reg  <= 2'd0;
            opt_reg   <= 8'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            verb_reg  <= verb_next;
            opt_reg   <= opt_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        verb_next      = verb_reg;
        opt_next       = opt_reg;
        emit           = 1'b0;
        res.kind       = KIND_DATA;
        res.value      = rx_byte;
        res.sub_option = 8'd0;
        unique case (phase_reg)
            PH_DATA: begin
                if (rx_byte == CODE_IAC) phase_next = PH_IAC;
                else                     emit = 1'b1;
            end
            PH_IAC: begin
                if (rx_byte == CODE_IAC) begin
                    phase_next = PH_DATA;
                    emit       = 1'b1;
                end else if (rx_byte >= CODE_WILL) begin
                    verb_next  = 2'(rx_byte - CODE_WILL);
                    phase_next = PH_VERB_OPT;
                end else if (rx_byte == CODE_SB) begin
                    phase_next = PH_SB_OPT;
                end else begin
                    phase_next = PH_DATA;   // unknown command dropped
                end
            end
            PH_VERB_OPT: begin
                res.kind = KIND_WILL + 3'(verb_reg);
                if (rx_byte == CODE_IAC) begin
                    phase_next = PH_VERB_ESC;
                end else begin
                    phase_next = PH_DATA;
                    emit       = 1'b1;
                end
            end
            PH_VERB_ESC: begin
                res.kind   = KIND_WILL + 3'(verb_reg);
                phase_next = PH_DATA;
                emit       = 1'b1;
            end
            PH_SB_OPT: begin
                if (rx_byte == CODE_IAC) begin
                    phase_next = PH_SB_OPT_ESC;
                end else begin
                    opt_next   = rx_byte;
                    phase_next = PH_SB_BODY;
                end
            end
            PH_SB_OPT_ESC: begin
                opt_next   = rx_byte;
                phase_next = PH_SB_BODY;
            end
            PH_SB_BODY: begin
                res.kind       = KIND_SBBYTE;
                res.sub_option = opt_reg;
                if (rx_byte == CODE_IAC) phase_next = PH_SB_BODY_ESC;
                else                     emit = 1'b1;
            end
            PH_SB_BODY_ESC: begin
                res.sub_option = opt_reg;
                emit           = 1'b1;
                if (rx_byte == CODE_SE) begin
                    res.kind   = KIND_SBEND;
                    res.value  = 8'd0;
                    phase_next = PH_DATA;
                end else begin
                    res.kind   = KIND_SBBYTE;
                    phase_next = PH_SB_BODY;
                end
            end
            default: begin
                phase_next = PH_DATA;
            end
        endcase
        res_valid = step_en && emit;
    end

    // SB end always returns the parser to plain data
    a_sbend_to_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_SBEND) |=> (phase_reg == PH_DATA))
        else $error("parser not in data phase after subnegotiation end");

    // negotiation and data results carry no option
    a_sub_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind != KIND_SBBYTE && res.kind != KIND_SBEND)
        |-> (res.sub_option == 8'd0))
        else $error("sub_option set on a non-subnegotiation result");

endmodule

// ===== rtl/core/tnrx_out_buf.sv =====
// Result register for the telnet parser: holds one word until the sink takes it.
// Uses tnrx_pkg.
module tnrx_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tnrx_pkg::result_t din,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_kind,
    output logic [7:0]        m_value,
    output logic [7:0]        m_sub_option
);
    import tnrx_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (free) valid_next = load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (free && load) data_reg <= din;
    end

    assign m_valid      = valid_reg;
    assign m_kind       = data_reg.kind;
    assign m_value      = data_reg.value;
    assign m_sub_option = data_reg.sub_option;

    // a new word is only offered when the slot is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("result word loaded over a pending one");

endmodule

// ===== rtl/core/telnet_receive_command_parser_top.sv =====
// Top level of the telnet receive command parser.
// Instantiates tnrx_parser and tnrx_out_buf; uses tnrx_pkg.
//
//  channel | direction | ports                                  | word
//  --------+-----------+----------------------------------------+---------------------
//  s_      | in        | s_valid, s_ready, s_rx_byte            | one received byte
//  m_      | out       | m_valid, m_ready, m_kind, m_value,     | one parse result
//          |           | m_sub_option                           |
//
//  Throughput: one byte per cycle while m_ready is high; bytes pass the input register, then the result register.
//  Bytes that produce no result (IAC prefixes, verbs, SB option bytes) are absorbed silently.
//  Reset (aresetn low, synchronous) empties both registers and returns to the data phase.
//  A stalled m_ channel holds the result; the input register then fills and s_ready drops.
module telnet_receive_command_parser_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_value,
    output logic [7:0] m_sub_option
);
    import tnrx_pkg::*;

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // byte leaves the input register whenever the result slot can take a word
    assign advance = in_vld_reg && out_free;
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) in_vld_next = 1'b1;
        else if (advance)       in_vld_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) in_vld_reg <= 1'b0;
        else          in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_byte_reg <= s_rx_byte;
    end

    tnrx_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    tnrx_out_buf u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (res_valid),
        .din          (res),
        .free         (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_value      (m_value),
        .m_sub_option (m_sub_option)
    );

    // an empty input register never blocks the source
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_ready)
        else $error("s_ready low with an empty input register");

endmodule
